>>> src/hpg_pkg.sv
// Package for the Halton point generator: shared widths, prime base tables,
// register codes and the word types that travel between pipeline stages.
// Depends on nothing; every other file imports it.
package hpg_pkg;

  localparam int unsigned MaxDims      = 30;
  localparam int unsigned IndexBits    = 32;
  localparam int unsigned FractionBits = 32;
  localparam int unsigned DimBits      = 5;
  localparam int unsigned BaseBits     = 7;
  // b^m stays below 2^32 * 113, so 40 bits hold the reversed digits and scale
  localparam int unsigned AccBits      = 40;
  localparam int unsigned DigitSteps   = IndexBits;  // base 2 has the most digits

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DIM_COUNT   = 2'd0,
    REG_START_INDEX = 2'd1
  } hpg_reg_e;

  // prime base per dimension, padded to the full index range
  localparam logic [BaseBits-1:0] PRIME [32] = '{
    7'd2,  7'd3,  7'd5,  7'd7,  7'd11, 7'd13, 7'd17, 7'd19, 7'd23, 7'd29,
    7'd31, 7'd37, 7'd41, 7'd43, 7'd47, 7'd53, 7'd59, 7'd61, 7'd67, 7'd71,
    7'd73, 7'd79, 7'd83, 7'd89, 7'd97, 7'd101, 7'd103, 7'd107, 7'd109, 7'd113,
    7'd2,  7'd2
  };

  // extra shift k per base: 2^k < b <= 2^(k+1), so the reciprocal fits 32 bits
  localparam logic [2:0] RSHIFT [32] = '{
    3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd6,
    3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
    3'd0, 3'd0
  };

  // floor(2^(32+k) / b)
  localparam logic [31:0] RECIP [32] = '{
    32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 33) / 64'd3),
    32'((64'd1 << 34) / 64'd5),   32'((64'd1 << 34) / 64'd7),
    32'((64'd1 << 35) / 64'd11),  32'((64'd1 << 35) / 64'd13),
    32'((64'd1 << 36) / 64'd17),  32'((64'd1 << 36) / 64'd19),
    32'((64'd1 << 36) / 64'd23),  32'((64'd1 << 36) / 64'd29),
    32'((64'd1 << 36) / 64'd31),  32'((64'd1 << 37) / 64'd37),
    32'((64'd1 << 37) / 64'd41),  32'((64'd1 << 37) / 64'd43),
    32'((64'd1 << 37) / 64'd47),  32'((64'd1 << 37) / 64'd53),
    32'((64'd1 << 37) / 64'd59),  32'((64'd1 << 37) / 64'd61),
    32'((64'd1 << 38) / 64'd67),  32'((64'd1 << 38) / 64'd71),
    32'((64'd1 << 38) / 64'd73),  32'((64'd1 << 38) / 64'd79),
    32'((64'd1 << 38) / 64'd83),  32'((64'd1 << 38) / 64'd89),
    32'((64'd1 << 38) / 64'd97),  32'((64'd1 << 38) / 64'd101),
    32'((64'd1 << 38) / 64'd103), 32'((64'd1 << 38) / 64'd107),
    32'((64'd1 << 38) / 64'd109), 32'((64'd1 << 38) / 64'd113),
    32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 32) / 64'd2)
  };

  // word in the digit-reversal part of the pipeline
  typedef struct packed {
    logic [IndexBits-1:0] n;      // index still to be split into digits
    logic [AccBits-1:0]   acc;    // digits reversed so far
    logic [AccBits-1:0]   scale;  // b^(digits taken)
    logic [BaseBits-1:0]  rem;    // digit from the previous step
    logic                 dig;    // previous step produced a digit
    logic [DimBits-1:0]   dim;
    logic                 last;
  } hpg_digit_t;

  // word in the fraction-division part of the pipeline
  typedef struct packed {
    logic [AccBits:0]        rem;
    logic [AccBits-1:0]      scale;
    logic [FractionBits-1:0] quo;
    logic [DimBits-1:0]      dim;
    logic                    last;
  } hpg_div_t;

endpackage

>>> src/halton_point_generator_unit.sv
// Halton point generator: radical inverse of (point + start index) in the
// first dimension_count prime bases, one coordinate per cycle per dimension.
// The pipeline has 1 sequencer, 64 digit-split, 1 fold and 32 division stages.
// The sequencer issues one dimension per cycle and takes the next point while
// it issues the last dimension of the current one; a rejected dimension count
// issues no words.
// Reset clears valid bits and the registers to one dimension, start 0.
module halton_point_generator_unit import hpg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [31:0]             cfg_data_i,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [IndexBits-1:0]    point_number_i,
  output logic                    result_valid_o,
  output logic [FractionBits-1:0] coordinate_o,
  output logic [DimBits-1:0]      dimension_o,
  output logic                    last_of_point_o
);

  logic [DimBits-1:0]   dim_count_q;
  logic [IndexBits-1:0] start_index_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q   <= DimBits'(1);
      start_index_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DIM_COUNT:   dim_count_q   <= cfg_data_i[DimBits-1:0];
        REG_START_INDEX: start_index_q <= cfg_data_i[IndexBits-1:0];
        default: ;
      endcase
    end
  end

  logic       dv [DigitSteps+1];
  hpg_digit_t dw [DigitSteps+1];

  hpg_sequencer u_seq (
    .clk_i,
    .rst_ni,
    .start_i,
    .point_number_i,
    .dim_count_i   (dim_count_q),
    .start_index_i (start_index_q),
    .busy_o,
    .issue_valid_o (dv[0]),
    .issue_o       (dw[0])
  );

  // split the index into digits, one digit per stage pair
  for (genvar k = 0; k < DigitSteps; k++) begin : g_digit
    hpg_digit_stage u_digit (
      .clk_i,
      .rst_ni,
      .valid_i (dv[k]),
      .word_i  (dw[k]),
      .valid_o (dv[k+1]),
      .word_o  (dw[k+1])
    );
  end

  // fold in the final digit and start the division
  logic                fold_valid_q;
  hpg_div_t            fold_q;
  hpg_digit_t          tail;
  logic [BaseBits-1:0] tail_base;
  logic [AccBits-1:0]  tail_acc, tail_scale;

  assign tail      = dw[DigitSteps];
  assign tail_base = PRIME[tail.dim];
  always_comb begin
    tail_acc   = tail.acc;
    tail_scale = tail.scale;
    if (tail.dig) begin
      tail_acc   = AccBits'(tail.acc * tail_base) + AccBits'(tail.rem);
      tail_scale = AccBits'(tail.scale * tail_base);
    end
  end

  always_ff @(posedge clk_i) begin
    fold_q.rem   <= {1'b0, tail_acc};
    fold_q.scale <= tail_scale;
    fold_q.quo   <= '0;
    fold_q.dim   <= tail.dim;
    fold_q.last  <= tail.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_valid_q <= 1'b0;
    end else begin
      fold_valid_q <= dv[DigitSteps];
    end
  end

  logic     qv [FractionBits+1];
  hpg_div_t qw [FractionBits+1];

  assign qv[0] = fold_valid_q;
  assign qw[0] = fold_q;

  // one fraction bit per stage
  for (genvar k = 0; k < FractionBits; k++) begin : g_div
    hpg_div_stage u_div (
      .clk_i,
      .rst_ni,
      .valid_i (qv[k]),
      .word_i  (qw[k]),
      .valid_o (qv[k+1]),
      .word_o  (qw[k+1])
    );
  end

  assign result_valid_o  = qv[FractionBits];
  assign coordinate_o    = qw[FractionBits].quo;
  assign dimension_o     = qw[FractionBits].dim;
  assign last_of_point_o = qw[FractionBits].last;

endmodule

>>> src/hpg_sequencer.sv
// Point sequencer: takes one point, forms the sequence index and issues one
// word per dimension into the pipeline. Depends on hpg_pkg.
module hpg_sequencer import hpg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [IndexBits-1:0] point_number_i,
  input  logic [DimBits-1:0]   dim_count_i,
  input  logic [IndexBits-1:0] start_index_i,
  output logic                 busy_o,
  output logic                 issue_valid_o,
  output hpg_digit_t           issue_o
);

  logic                 busy_q, busy_d;
  logic [IndexBits-1:0] n_q, n_d;
  logic [DimBits-1:0]   dim_q, dim_d;
  logic [DimBits-1:0]   cnt_q, cnt_d;
  logic                 issue_last;
  logic                 accept;

  assign issue_last = (dim_q == cnt_q - DimBits'(1));
  assign busy_o     = busy_q && !issue_last;
  assign accept     = start_i && !busy_o;

  // advance through the dimensions, take the next point on the last one
  always_comb begin
    busy_d = busy_q;
    n_d    = n_q;
    dim_d  = dim_q;
    cnt_d  = cnt_q;
    if (busy_q) begin
      dim_d = dim_q + DimBits'(1);
      if (issue_last) busy_d = 1'b0;
    end
    if (accept) begin
      n_d    = point_number_i + start_index_i;
      dim_d  = '0;
      cnt_d  = dim_count_i;
      busy_d = (dim_count_i != '0) && (dim_count_i <= DimBits'(MaxDims));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      dim_q  <= '0;
      cnt_q  <= DimBits'(1);
    end else begin
      busy_q <= busy_d;
      dim_q  <= dim_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
  end

  assign issue_valid_o = busy_q;
  always_comb begin
    issue_o       = '0;
    issue_o.n     = n_q;
    issue_o.scale = AccBits'(1);
    issue_o.dim   = dim_q;
    issue_o.last  = issue_last;
  end

endmodule

>>> src/hpg_digit_stage.sv
// One digit step of the base-b split: two register stages. The first
// multiplies by the base reciprocal and folds in the previous digit, the
// second corrects the quotient and yields the digit. Depends on hpg_pkg.
module hpg_digit_stage import hpg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  hpg_digit_t word_i,
  output logic       valid_o,
  output hpg_digit_t word_o
);

  logic [BaseBits-1:0] base_a;
  logic                valid_a_q, valid_b_q;
  hpg_digit_t          word_a_q, word_a_d, word_b_q, word_b_d;
  logic [63:0]         prod_q;

  logic [BaseBits-1:0]  base_b;
  logic [IndexBits-1:0] q_est;
  logic [IndexBits-1:0] r_est;

  assign base_a = PRIME[word_i.dim];

  // fold the previous digit into the reversed value
  always_comb begin
    word_a_d = word_i;
    if (word_i.dig) begin
      word_a_d.acc   = AccBits'(word_i.acc * base_a) + AccBits'(word_i.rem);
      word_a_d.scale = AccBits'(word_i.scale * base_a);
    end
  end

  always_ff @(posedge clk_i) begin
    word_a_q <= word_a_d;
    prod_q   <= 64'(word_i.n) * 64'(RECIP[word_i.dim]);
    word_b_q <= word_b_d;
  end

  // quotient estimate is low by at most one; fix it and take the digit
  assign base_b = PRIME[word_a_q.dim];
  assign q_est  = IndexBits'(prod_q >> (7'd32 + 7'(RSHIFT[word_a_q.dim])));
  assign r_est  = word_a_q.n - IndexBits'(q_est * base_b);

  always_comb begin
    word_b_d     = word_a_q;
    word_b_d.dig = (word_a_q.n != '0);
    word_b_d.n   = q_est;
    word_b_d.rem = r_est[BaseBits-1:0];
    if (r_est >= IndexBits'(base_b)) begin
      word_b_d.n   = q_est + IndexBits'(1);
      word_b_d.rem = BaseBits'(r_est - IndexBits'(base_b));
    end
    if (word_a_q.n == '0) begin
      word_b_d.n   = '0;
      word_b_d.rem = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  assign valid_o = valid_b_q;
  assign word_o  = word_b_q;

endmodule

>>> src/hpg_div_stage.sv
// One quotient bit of the fraction division acc * 2^32 / scale.
// Depends on hpg_pkg.
module hpg_div_stage import hpg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  hpg_div_t word_i,
  output logic     valid_o,
  output hpg_div_t word_o
);

  logic     valid_q;
  hpg_div_t word_q, word_d;
  logic [AccBits:0] rem2;

  // shift the remainder, subtract when it reaches the scale
  always_comb begin
    rem2   = {word_i.rem[AccBits-1:0], 1'b0};
    word_d = word_i;
    word_d.quo = {word_i.quo[FractionBits-2:0], 1'b0};
    word_d.rem = rem2;
    if (rem2 >= {1'b0, word_i.scale}) begin
      word_d.rem    = rem2 - {1'b0, word_i.scale};
      word_d.quo[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

>>> src/hpg_checker.sv
// Port-level checks on the result stream of the Halton point generator,
// bound to the top level. Depends on hpg_pkg.
module hpg_checker import hpg_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_ready_o,
  input logic               result_valid_o,
  input logic [DimBits-1:0] dimension_o,
  input logic               last_of_point_o
);

  // a point's coordinates come in back-to-back cycles, dimension rising
  a_dim_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_of_point_o |=>
      result_valid_o && (dimension_o == DimBits'($past(dimension_o) + 1'b1)))
    else $error("dimension sequence broken inside a point");

  // a point opens at dimension zero
  a_first_dim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (!$past(result_valid_o) || $past(last_of_point_o)) |->
      dimension_o == '0)
    else $error("point does not start at dimension zero");

  // dimensions stay within the prime table
  a_dim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> dimension_o < DimBits'(MaxDims))
    else $error("dimension out of range");

  // configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind halton_point_generator_unit hpg_checker u_hpg_checker (
  .clk_i,
  .rst_ni,
  .cfg_ready_o,
  .result_valid_o,
  .dimension_o,
  .last_of_point_o
);
